>>> hw/rtl/dsma_pkg.sv
// Shared constants and command struct for the dual sensor moving average block.
package dsma_pkg;

  // Default build values
  localparam int WINDOW_DEF      = 30;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int FS_W  = 16;
  localparam int C_W   = 16;
  localparam int F_W   = 17;

  // Quotient bits of every lane (covers the Fahrenheit range)
  localparam int QUO_W = 17;

  // Compare-and-subtract passes that settle a reciprocal estimate
  localparam int FIX_STEPS = 2;
  localparam int STEP_W    = $clog2(FIX_STEPS);

  // Full scale after reset: 3.3 V at 10 mV per degree, in hundredths of a degree
  localparam logic [FS_W-1:0] FS_RESET = 16'd33000;

  // Fahrenheit offset, 32 degrees in hundredths
  localparam logic [F_W-1:0] F_OFFSET = 17'd3200;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;   // latch the sample beat and read the oldest ring entry
    logic update;    // adjust the window sums and write the new entry
    logic mul;       // scale the sums by the full scale
    logic load;      // form the Fahrenheit dividend
    logic rcp;       // estimate every quotient by reciprocal multiply
    logic rem;       // form every remainder from its estimate
    logic fix;       // settle one correction step in every lane
    logic out_load;  // move the quotients into the result register
  } dsma_cmd_t;

endpackage

>>> hw/rtl/dsma_sample_if.sv
// Input channel: one beat carries a pair of raw sensor codes.
interface dsma_sample_if #(
  parameter int SAMPLE_BITS = dsma_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_low;
  logic [SAMPLE_BITS-1:0] sample_high;

  modport source (output valid, output sample_low, output sample_high, input ready);
  modport sink   (input valid, input sample_low, input sample_high, output ready);
endinterface

>>> hw/rtl/dsma_temp_if.sv
// Result channel: one beat carries the averaged temperatures.
interface dsma_temp_if;
  logic                       valid;
  logic                       ready;
  logic [dsma_pkg::C_W-1:0]   temp_low_centi_c;
  logic [dsma_pkg::C_W-1:0]   temp_high_centi_c;
  logic [dsma_pkg::F_W-1:0]   temp_low_centi_f;

  modport source (output valid, output temp_low_centi_c, output temp_high_centi_c,
                  output temp_low_centi_f, input ready);
  modport sink   (input valid, input temp_low_centi_c, input temp_high_centi_c,
                  input temp_low_centi_f, output ready);
endinterface

>>> hw/rtl/dsma_ctrl.sv
// Sequencer for the moving average block: drives the datapath and the result valid.
module dsma_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dsma_pkg::dsma_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_UPD  = 8'b00000010,
    S_MUL  = 8'b00000100,
    S_LOAD = 8'b00001000,
    S_RCP  = 8'b00010000,
    S_REM  = 8'b00100000,
    S_FIX  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [dsma_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Decode the next state and the datapath commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_RCP;
      end
      S_RCP: begin
        cmd.rcp   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        step_nxt  = dsma_pkg::STEP_W'(dsma_pkg::FIX_STEPS - 1);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_DONE: begin
        // hold the finished result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Raise valid on a load, drop it once the beat is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted beat always starts the ring update next cycle
  a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_UPD))
    else $error("accepted beat did not start the update");

  // The correction runs exactly FIX_STEPS steps
  a_fix_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM) |=> ##(dsma_pkg::FIX_STEPS) (state_r == S_DONE))
    else $error("correction step count wrong");

  // A new result appears only out of the done state
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid raised outside done state");

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("pending result overwritten");
`endif

endmodule

>>> hw/rtl/dsma_dp.sv
// Datapath: shared sample ring, window sums, full-scale multiply and three reciprocal divider lanes.
module dsma_dp #(
  parameter int WINDOW      = dsma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = dsma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dsma_pkg::dsma_cmd_t        cmd,
  input  logic                       cfg_we,
  input  logic [dsma_pkg::FS_W-1:0]  cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]     sample_low,
  input  logic [SAMPLE_BITS-1:0]     sample_high,
  output logic [dsma_pkg::C_W-1:0]   temp_low_centi_c,
  output logic [dsma_pkg::C_W-1:0]   temp_high_centi_c,
  output logic [dsma_pkg::F_W-1:0]   temp_low_centi_f
);

  localparam longint CODE_MAX = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint DEN      = longint'(WINDOW) * CODE_MAX;
  localparam longint DEN5     = DEN * 5;
  localparam int     SUM_W    = $clog2(DEN + 1);
  localparam int     DEN_W    = $clog2(DEN + 1);
  localparam int     DEN5_W   = $clog2(DEN5 + 1);
  localparam int     PROD_W   = SUM_W + dsma_pkg::FS_W;
  localparam int     NF_W     = PROD_W + 4;
  localparam int     SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int     QW       = dsma_pkg::QUO_W;

  // Reciprocal estimate: drop low dividend bits worth at most half a divisor,
  // scale by floor(2^K / divisor) with K the dividend width
  localparam int     SH_C     = DEN_W - 2;
  localparam int     SH_F     = DEN5_W - 2;
  localparam int     XT_C_W   = PROD_W - SH_C;
  localparam int     XT_F_W   = NF_W - SH_F;
  localparam longint RCP_C    = (longint'(1) << PROD_W) / DEN;
  localparam longint RCP_F    = (longint'(1) << NF_W) / DEN5;
  localparam int     RC_W     = $clog2(RCP_C + 1);
  localparam int     RF_W     = $clog2(RCP_F + 1);
  localparam int     EC_W     = XT_C_W + RC_W;
  localparam int     EF_W     = XT_F_W + RF_W;
  localparam int     RMC_W    = DEN_W + 2;
  localparam int     RMF_W    = DEN5_W + 2;

  localparam logic [RC_W-1:0]   RCP_C_K = RC_W'(RCP_C);
  localparam logic [RF_W-1:0]   RCP_F_K = RF_W'(RCP_F);
  localparam logic [PROD_W-1:0] DEN_P   = PROD_W'(DEN);
  localparam logic [NF_W-1:0]   DEN5_P  = NF_W'(DEN5);
  localparam logic [RMC_W-1:0]  DEN_R   = RMC_W'(DEN);
  localparam logic [RMF_W-1:0]  DEN5_R  = RMF_W'(DEN5);

  // Configuration
  logic [dsma_pkg::FS_W-1:0] fs_r;

  // Ring storage: both channels share one word per slot
  logic [2*SAMPLE_BITS-1:0]  ring_mem [WINDOW];
  logic [WINDOW-1:0]         vld_r;
  logic [2*SAMPLE_BITS-1:0]  rd_r;
  logic                      rd_vld_r;
  logic [SLOT_W-1:0]         slot_r;

  logic [SAMPLE_BITS-1:0]    smp_lo_r, smp_hi_r;
  logic [SAMPLE_BITS-1:0]    old_lo, old_hi;
  logic [SUM_W-1:0]          sum_lo_r, sum_hi_r;

  logic [PROD_W-1:0]         prod_lo_r, prod_hi_r;
  logic [NF_W-1:0]           nf;
  logic [NF_W-1:0]           xf_r;

  logic [XT_C_W-1:0]         xt_lo, xt_hi;
  logic [XT_F_W-1:0]         xt_f;
  logic [EC_W-1:0]           est_lo, est_hi;
  logic [EF_W-1:0]           est_f;

  logic [RMC_W-1:0]          rem_lo_r, rem_hi_r;
  logic [RMF_W-1:0]          rem_f_r;
  logic [QW-1:0]             q_lo_r, q_hi_r, q_f_r;
  logic                      ge_lo, ge_hi, ge_f;

  logic [dsma_pkg::C_W-1:0]  out_lo_c_r, out_hi_c_r;
  logic [dsma_pkg::F_W-1:0]  out_lo_f_r;

  // Full-scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= dsma_pkg::FS_RESET;
    end else if (cfg_we) begin
      fs_r <= cfg_wdata;
    end
  end

  // Read the oldest entry as the beat is latched
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_lo_r <= sample_low;
      smp_hi_r <= sample_high;
      rd_r     <= ring_mem[slot_r];
      rd_vld_r <= vld_r[slot_r];
    end
  end

  // Write the new entry over the oldest one
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring_mem[slot_r] <= {smp_lo_r, smp_hi_r};
    end
  end

  // An entry never written reads as zero
  assign old_lo = rd_vld_r ? rd_r[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
  assign old_hi = rd_vld_r ? rd_r[SAMPLE_BITS-1:0] : '0;

  // Window sums, slot pointer and entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_lo_r <= '0;
      sum_hi_r <= '0;
      slot_r   <= '0;
      vld_r    <= '0;
    end else if (cmd.update) begin
      sum_lo_r      <= sum_lo_r - SUM_W'(old_lo) + SUM_W'(smp_lo_r);
      sum_hi_r      <= sum_hi_r - SUM_W'(old_hi) + SUM_W'(smp_hi_r);
      vld_r[slot_r] <= 1'b1;
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // Scale both sums by the full scale
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_lo_r <= PROD_W'(sum_lo_r) * PROD_W'(fs_r);
      prod_hi_r <= PROD_W'(sum_hi_r) * PROD_W'(fs_r);
    end
  end

  // Times nine for the Fahrenheit lane, by shift and add
  assign nf = (NF_W'(prod_lo_r) << 3) + NF_W'(prod_lo_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xf_r <= nf;
    end
  end

  // Reciprocal products on the top dividend bits
  assign xt_lo  = prod_lo_r[PROD_W-1:SH_C];
  assign xt_hi  = prod_hi_r[PROD_W-1:SH_C];
  assign xt_f   = xf_r[NF_W-1:SH_F];
  assign est_lo = EC_W'(xt_lo) * EC_W'(RCP_C_K);
  assign est_hi = EC_W'(xt_hi) * EC_W'(RCP_C_K);
  assign est_f  = EF_W'(xt_f) * EF_W'(RCP_F_K);

  // The estimate sits at most two below the quotient, so each remainder is
  // under three divisors; two compare-and-subtract passes settle it
  assign ge_lo = (rem_lo_r >= DEN_R);
  assign ge_hi = (rem_hi_r >= DEN_R);
  assign ge_f  = (rem_f_r  >= DEN5_R);

  always_ff @(posedge clk) begin
    if (cmd.rcp) begin
      q_lo_r <= QW'(est_lo >> XT_C_W);
      q_hi_r <= QW'(est_hi >> XT_C_W);
      q_f_r  <= QW'(est_f >> XT_F_W);
    end else if (cmd.rem) begin
      rem_lo_r <= RMC_W'(prod_lo_r - PROD_W'(q_lo_r) * DEN_P);
      rem_hi_r <= RMC_W'(prod_hi_r - PROD_W'(q_hi_r) * DEN_P);
      rem_f_r  <= RMF_W'(xf_r - NF_W'(q_f_r) * DEN5_P);
    end else if (cmd.fix) begin
      rem_lo_r <= ge_lo ? (rem_lo_r - DEN_R) : rem_lo_r;
      rem_hi_r <= ge_hi ? (rem_hi_r - DEN_R) : rem_hi_r;
      rem_f_r  <= ge_f  ? (rem_f_r - DEN5_R) : rem_f_r;
      q_lo_r   <= q_lo_r + QW'(ge_lo);
      q_hi_r   <= q_hi_r + QW'(ge_hi);
      q_f_r    <= q_f_r + QW'(ge_f);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lo_c_r <= q_lo_r[dsma_pkg::C_W-1:0];
      out_hi_c_r <= q_hi_r[dsma_pkg::C_W-1:0];
      out_lo_f_r <= dsma_pkg::F_W'(q_f_r) + dsma_pkg::F_OFFSET;
    end
  end

  assign temp_low_centi_c  = out_lo_c_r;
  assign temp_high_centi_c = out_hi_c_r;
  assign temp_low_centi_f  = out_lo_f_r;

endmodule

>>> hw/rtl/dual_sensor_moving_average_temp.sv
// The sequencer walks each accepted input beat through ring update, scaling, Fahrenheit
// dividend, reciprocal estimate, remainder and two correction steps before its result
// loads; no new input beat is taken until that result has moved to the output register.
// A new input beat is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) clears sums, slot pointer, ring valid bits and the result valid
// at once and loads the full scale with 33000; no clearing pass is needed.
module dual_sensor_moving_average_temp #(
  parameter int WINDOW      = dsma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = dsma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [dsma_pkg::FS_W-1:0] cfg_wdata,
  dsma_sample_if.sink               in_ch,
  dsma_temp_if.source               out_ch
);

  dsma_pkg::dsma_cmd_t cmd;
  logic                in_ready;
  logic                out_valid;

  // Sequencer
  dsma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath
  dsma_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .sample_low        (in_ch.sample_low),
    .sample_high       (in_ch.sample_high),
    .temp_low_centi_c  (out_ch.temp_low_centi_c),
    .temp_high_centi_c (out_ch.temp_high_centi_c),
    .temp_low_centi_f  (out_ch.temp_low_centi_f)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
